>>> rtl/ppa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppa_pkg
// Shared constants, codes and controller/datapath handshake types for the
// priority prefix autocomplete block.
// ----------------------------------------------------------------------------
package ppa_pkg;

    localparam int TABLE_ENTRIES_DEF = 64;
    localparam int MAX_WORD_LEN_DEF  = 20;

    localparam int          COUNT_W   = 16;
    localparam logic [15:0] COUNT_MAX = 16'hFFFF;

    localparam logic [7:0] CHAR_STAR = 8'h2A;
    localparam logic [7:0] CHAR_A    = 8'h61;
    localparam logic [7:0] CHAR_Z    = 8'h7A;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TEXT = 1'b1;

    localparam logic [1:0] EMIT_WORD = 2'd0;
    localparam logic [1:0] EMIT_HIT  = 2'd1;
    localparam logic [1:0] EMIT_DROP = 2'd2;

    typedef struct packed {
        logic       accept;
        logic       prep;
        logic       scan_clr;
        logic       scan_rd;
        logic       scan_ev;
        logic       sh_init;
        logic       sh_rd;
        logic       sh_wr;
        logic       wr_new;
        logic       bump;
        logic       emit_init;
        logic [1:0] emit_src;
        logic       emit_step;
    } ppa_cmd_t;

    typedef struct packed {
        logic op_text;
        logic is_star;
        logic nonword;
        logic scan_end;
        logic hit_found;
        logic tbl_full;
        logic sh_end;
        logic emit_last;
        logic out_free;
    } ppa_sts_t;

endpackage

>>> rtl/ppa_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppa_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module ppa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/ppa_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppa_ctrl
// Sequencer: buffers a word, scans the table unless the token is a non-word,
// shifts/inserts or bumps, then streams any emitted word out.
// ----------------------------------------------------------------------------
module ppa_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_last,
    output logic              in_stall,
    input  ppa_pkg::ppa_sts_t sts,
    output ppa_pkg::ppa_cmd_t cmd
);
    import ppa_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_PREP   = 4'd1;
    localparam logic [3:0] S_ROUTE  = 4'd2;
    localparam logic [3:0] S_SC_RD  = 4'd3;
    localparam logic [3:0] S_SC_EV  = 4'd4;
    localparam logic [3:0] S_DECIDE = 4'd5;
    localparam logic [3:0] S_SH_RD  = 4'd6;
    localparam logic [3:0] S_SH_WR  = 4'd7;
    localparam logic [3:0] S_WR_NEW = 4'd8;
    localparam logic [3:0] S_BUMP   = 4'd9;
    localparam logic [3:0] S_EMIT   = 4'd10;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                cmd.accept = in_valid;
                if (in_valid && in_last)
                begin
                    state_next = S_PREP;
                end
            end
            S_PREP:
            begin
                cmd.prep   = 1'b1;
                state_next = S_ROUTE;
            end
            S_ROUTE:
            begin
                if (sts.nonword)
                begin
                    cmd.emit_init = 1'b1;
                    cmd.emit_src  = EMIT_WORD;
                    state_next    = S_EMIT;
                end
                else
                begin
                    cmd.scan_clr = 1'b1;
                    state_next   = S_SC_RD;
                end
            end
            S_SC_RD:
            begin
                if (sts.scan_end)
                begin
                    state_next = S_DECIDE;
                end
                else
                begin
                    cmd.scan_rd = 1'b1;
                    state_next  = S_SC_EV;
                end
            end
            S_SC_EV:
            begin
                cmd.scan_ev = 1'b1;
                state_next  = S_SC_RD;
            end
            S_DECIDE:
            begin
                if (!sts.op_text || !sts.hit_found)
                begin
                    cmd.sh_init = 1'b1;
                    if (sts.tbl_full)
                    begin
                        cmd.emit_init = 1'b1;
                        cmd.emit_src  = sts.op_text ? EMIT_WORD : EMIT_DROP;
                        state_next    = S_EMIT;
                    end
                    else
                    begin
                        state_next = S_SH_RD;
                    end
                end
                else
                begin
                    state_next = S_BUMP;
                end
            end
            S_SH_RD:
            begin
                if (sts.sh_end)
                begin
                    state_next = S_WR_NEW;
                end
                else
                begin
                    cmd.sh_rd  = 1'b1;
                    state_next = S_SH_WR;
                end
            end
            S_SH_WR:
            begin
                cmd.sh_wr  = 1'b1;
                state_next = S_SH_RD;
            end
            S_WR_NEW:
            begin
                cmd.wr_new = 1'b1;
                if (sts.op_text)
                begin
                    cmd.emit_init = 1'b1;
                    cmd.emit_src  = EMIT_WORD;
                    state_next    = S_EMIT;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_BUMP:
            begin
                cmd.bump      = 1'b1;
                cmd.emit_init = 1'b1;
                cmd.emit_src  = sts.is_star ? EMIT_WORD : EMIT_HIT;
                state_next    = S_EMIT;
            end
            S_EMIT:
            begin
                cmd.emit_step = 1'b1;
                if (sts.out_free && sts.emit_last)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

>>> rtl/ppa_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppa_dp
// Datapath: token buffer, table RAM, scan compare, shift/insert, output
// register.
// ----------------------------------------------------------------------------
module ppa_dp #(
    parameter int TABLE_ENTRIES = ppa_pkg::TABLE_ENTRIES_DEF,
    parameter int MAX_WORD_LEN  = ppa_pkg::MAX_WORD_LEN_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  ppa_pkg::ppa_cmd_t cmd,
    output ppa_pkg::ppa_sts_t sts,
    input  logic              opcode,
    input  logic [7:0]        in_char,
    input  logic              in_last,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [7:0]        out_char,
    output logic              out_last,
    output logic              table_full
);
    import ppa_pkg::*;

    localparam int IW = $clog2(TABLE_ENTRIES);
    localparam int UW = $clog2(TABLE_ENTRIES + 1);
    localparam int LW = $clog2(MAX_WORD_LEN + 1);
    localparam int BW = $clog2(MAX_WORD_LEN);
    localparam int CW = 8 * MAX_WORD_LEN;
    localparam int RW = CW + LW + COUNT_W;

    // token buffer
    logic [7:0]    buf_reg [MAX_WORD_LEN];
    logic [LW-1:0] tlen_reg;
    logic [LW-1:0] tlen_inc;
    logic [7:0]    lastch_reg;
    logic [LW-1:0] n_reg;
    logic [LW-1:0] neff_reg;
    logic          op_reg;
    logic          star_reg;
    logic          nonword_reg;
    logic          full_reg;

    // table state
    logic [UW-1:0] used_reg;
    logic [UW-1:0] idx_reg;
    logic [UW-1:0] sidx_reg;
    logic [UW-1:0] pos_reg;
    logic          pos_found_reg;
    logic          hit_found_reg;
    logic [UW-1:0] hit_idx_reg;
    logic [RW-1:0] hit_row_reg;

    // emit
    logic [LW-1:0] k_reg;
    logic [1:0]    src_reg;
    logic          out_valid_reg;
    logic [7:0]    out_char_reg;
    logic          out_last_reg;
    logic          out_full_reg;

    // RAM
    logic          ram_we;
    logic [IW-1:0] ram_waddr;
    logic [RW-1:0] ram_wdata;
    logic [IW-1:0] ram_raddr;
    logic [RW-1:0] ram_rdata;

    ppa_ram #(
        .WIDTH (RW),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // row fields
    logic [CW-1:0]      r_chars;
    logic [LW-1:0]      r_len;
    logic [COUNT_W-1:0] r_cnt;
    logic [CW-1:0]      w_chars;

    assign r_chars = ram_rdata[RW-1 -: CW];
    assign r_len   = ram_rdata[COUNT_W +: LW];
    assign r_cnt   = ram_rdata[COUNT_W-1:0];

    always_comb
    begin
        for (int i = 0; i < MAX_WORD_LEN; i++)
        begin
            w_chars[8*i +: 8] = buf_reg[i];
        end
    end

    // compare table row against the stripped token
    logic [LW-1:0] m_len;
    logic          diff_found;
    logic          diff_lt;
    logic          pre_eq;
    logic          cmp_lt;
    logic          cmp_eq;
    logic          starts;

    always_comb
    begin
        m_len      = (r_len < neff_reg) ? r_len : neff_reg;
        diff_found = 1'b0;
        diff_lt    = 1'b0;
        pre_eq     = 1'b1;
        for (int i = MAX_WORD_LEN - 1; i >= 0; i--)
        begin
            if ((LW'(i) < m_len) && (r_chars[8*i +: 8] != buf_reg[i]))
            begin
                diff_found = 1'b1;
                diff_lt    = r_chars[8*i +: 8] < buf_reg[i];
            end
            if ((LW'(i) < neff_reg) && (r_chars[8*i +: 8] != buf_reg[i]))
            begin
                pre_eq = 1'b0;
            end
        end
        cmp_lt = diff_found ? diff_lt : (r_len < neff_reg);
        cmp_eq = !diff_found && (r_len == neff_reg);
        starts = (r_len >= neff_reg) && pre_eq;
    end

    // RAM port selection
    logic [UW-1:0]      sidx_dec;
    logic [COUNT_W-1:0] hit_cnt;
    logic [COUNT_W-1:0] hit_cnt_inc;

    assign sidx_dec    = sidx_reg - UW'(1);
    assign hit_cnt     = hit_row_reg[COUNT_W-1:0];
    assign hit_cnt_inc = (hit_cnt == COUNT_MAX) ? hit_cnt : hit_cnt + COUNT_W'(1);

    always_comb
    begin
        ram_raddr = cmd.sh_rd ? sidx_dec[IW-1:0] : idx_reg[IW-1:0];
        ram_we    = cmd.sh_wr || cmd.wr_new || cmd.bump;
        ram_waddr = sidx_reg[IW-1:0];
        ram_wdata = ram_rdata;
        if (cmd.wr_new)
        begin
            ram_waddr = pos_reg[IW-1:0];
            ram_wdata = {w_chars, neff_reg,
                         (op_reg == OP_TEXT) ? COUNT_W'(1) : COUNT_W'(0)};
        end
        else if (cmd.bump)
        begin
            ram_waddr = hit_idx_reg[IW-1:0];
            ram_wdata = {hit_row_reg[RW-1:COUNT_W], hit_cnt_inc};
        end
    end

    assign tlen_inc = (tlen_reg < LW'(MAX_WORD_LEN)) ? tlen_reg + LW'(1) : tlen_reg;

    // emit selection
    logic [LW-1:0] emit_len;
    logic [LW-1:0] emit_end;
    logic [7:0]    emit_byte;
    logic          out_free;

    always_comb
    begin
        case (src_reg)
            EMIT_HIT:
            begin
                emit_len  = hit_row_reg[COUNT_W +: LW];
                emit_byte = hit_row_reg[CW - 8 * MAX_WORD_LEN + COUNT_W + LW
                                        + 8 * k_reg[BW-1:0] +: 8];
            end
            EMIT_DROP:
            begin
                emit_len  = '0;
                emit_byte = '0;
            end
            default:
            begin
                emit_len  = neff_reg;
                emit_byte = buf_reg[k_reg[BW-1:0]];
            end
        endcase
        if (k_reg >= emit_len)
        begin
            emit_byte = '0;
        end
        emit_end = (emit_len == '0) ? '0 : emit_len - LW'(1);
    end

    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        sts.op_text   = (op_reg == OP_TEXT);
        sts.is_star   = star_reg;
        sts.nonword   = nonword_reg;
        sts.scan_end  = (idx_reg == used_reg);
        sts.hit_found = hit_found_reg;
        sts.tbl_full  = (used_reg == UW'(TABLE_ENTRIES));
        sts.sh_end    = (sidx_reg == pos_reg);
        sts.emit_last = (k_reg == emit_end);
        sts.out_free  = out_free;
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.accept && (tlen_reg < LW'(MAX_WORD_LEN)))
        begin
            buf_reg[tlen_reg[BW-1:0]] <= in_char;
            lastch_reg                <= in_char;
        end
        if (cmd.accept && in_last)
        begin
            n_reg  <= tlen_inc;
            op_reg <= opcode;
        end
        if (cmd.prep)
        begin
            star_reg    <= (op_reg == OP_TEXT) && (lastch_reg == CHAR_STAR);
            neff_reg    <= ((op_reg == OP_TEXT) && (lastch_reg == CHAR_STAR))
                           ? n_reg - LW'(1) : n_reg;
            nonword_reg <= (op_reg == OP_TEXT) && (lastch_reg != CHAR_STAR)
                           && (((n_reg == LW'(1)) && (buf_reg[0] < CHAR_A))
                               || (buf_reg[0] > CHAR_Z));
        end
        if (cmd.scan_ev)
        begin
            if (!pos_found_reg && !cmp_lt)
            begin
                pos_reg <= idx_reg;
            end
            if (star_reg ? (!hit_found_reg && cmp_eq)
                         : (starts && (!hit_found_reg || (r_cnt > hit_cnt))))
            begin
                hit_idx_reg <= idx_reg;
                hit_row_reg <= ram_rdata;
            end
        end
        if (cmd.scan_clr)
        begin
            pos_reg <= used_reg;
        end
        if (cmd.sh_init)
        begin
            sidx_reg <= used_reg;
        end
        if (cmd.sh_wr)
        begin
            sidx_reg <= sidx_dec;
        end
        if (cmd.emit_init)
        begin
            src_reg <= cmd.emit_src;
        end
        if (cmd.emit_step && out_free)
        begin
            out_char_reg <= emit_byte;
            out_last_reg <= (k_reg == emit_end);
            out_full_reg <= full_reg;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tlen_reg      <= '0;
            used_reg      <= '0;
            idx_reg       <= '0;
            pos_found_reg <= 1'b0;
            hit_found_reg <= 1'b0;
            full_reg      <= 1'b0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.accept)
            begin
                tlen_reg <= in_last ? '0 : tlen_inc;
            end
            if (cmd.prep)
            begin
                full_reg <= 1'b0;
            end
            if (cmd.scan_clr)
            begin
                idx_reg       <= '0;
                pos_found_reg <= 1'b0;
                hit_found_reg <= 1'b0;
            end
            if (cmd.scan_ev)
            begin
                idx_reg <= idx_reg + UW'(1);
                if (!cmp_lt)
                begin
                    pos_found_reg <= 1'b1;
                end
                if (star_reg ? cmp_eq : starts)
                begin
                    hit_found_reg <= 1'b1;
                end
            end
            if (cmd.sh_init)
            begin
                full_reg <= (used_reg == UW'(TABLE_ENTRIES));
            end
            if (cmd.wr_new)
            begin
                used_reg <= used_reg + UW'(1);
            end
            if (cmd.emit_init)
            begin
                k_reg <= '0;
            end
            if (cmd.emit_step && out_free)
            begin
                k_reg         <= k_reg + LW'(1);
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_char   = out_char_reg;
    assign out_last   = out_last_reg;
    assign table_full = out_full_reg;

endmodule

>>> rtl/priority_prefix_autocomplete.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// priority_prefix_autocomplete
// Sorted word table with use counts; completes text tokens to the most used
// matching entry and learns new words.
//
//   channel | handshake            | word
//   --------+----------------------+---------------------------------
//   in      | in_valid / in_stall  | opcode, in_char, in_last
//   out     | out_valid/ out_stall | out_char, out_last, table_full
//
// A word end prepares the token, then scans the table entry by entry, each
// step a registered RAM read and a compare. An insert at place P shifts the
// entries from P upward by one, a read and a write each, then writes the new
// row; a count bump writes the hit row back. Output goes one character per
// cycle unless stalled. A non-word token skips the scan.
// Reset empties the table at once; no clearing pass.
// A stalled output holds the sequencer in the emit step.
// ----------------------------------------------------------------------------
module priority_prefix_autocomplete #(
    parameter int TABLE_ENTRIES = ppa_pkg::TABLE_ENTRIES_DEF,
    parameter int MAX_WORD_LEN  = ppa_pkg::MAX_WORD_LEN_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       opcode,
    input  logic [7:0] in_char,
    input  logic       in_last,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_char,
    output logic       out_last,
    output logic       table_full
);
    import ppa_pkg::*;

    ppa_cmd_t cmd;
    ppa_sts_t sts;

    ppa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_last  (in_last),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    ppa_dp #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .MAX_WORD_LEN  (MAX_WORD_LEN)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .opcode     (opcode),
        .in_char    (in_char),
        .in_last    (in_last),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_char   (out_char),
        .out_last   (out_last),
        .table_full (table_full)
    );

endmodule

>>> sim/ppa_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppa_checker
// Watches both channels of the autocomplete block, keeps its own copy of the
// word table, predicts every emitted character and compares it on arrival.
// ----------------------------------------------------------------------------
module ppa_checker #(
    parameter int TABLE_ENTRIES = 64,
    parameter int MAX_WORD_LEN  = 20
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_stall,
    input  logic       opcode,
    input  logic [7:0] in_char,
    input  logic       in_last,
    input  logic       out_valid,
    input  logic       out_stall,
    input  logic [7:0] out_char,
    input  logic       out_last,
    input  logic       table_full,
    output int         fail_count,
    output int         pending
);
    import ppa_pkg::*;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
        logic       full;
    } out_word_t;

    typedef logic [7:0] word_t [MAX_WORD_LEN];

    word_t       tbl_chars [TABLE_ENTRIES];
    int          tbl_len   [TABLE_ENTRIES];
    logic [15:0] tbl_cnt   [TABLE_ENTRIES];
    int          used;
    word_t       tok;
    int          tok_len;
    out_word_t   emitted_q [$];

    function automatic int compare_entry(int e, word_t w, int n);
        int m;
        m = (tbl_len[e] < n) ? tbl_len[e] : n;
        for (int i = 0; i < m; i++)
            if (tbl_chars[e][i] != w[i])
                return (tbl_chars[e][i] < w[i]) ? -1 : 1;
        if (tbl_len[e] == n)
            return 0;
        return (tbl_len[e] < n) ? -1 : 1;
    endfunction

    function automatic bit has_prefix(int e, word_t w, int n);
        if (tbl_len[e] < n)
            return 0;
        for (int i = 0; i < n; i++)
            if (tbl_chars[e][i] != w[i])
                return 0;
        return 1;
    endfunction

    // returns 1 when dropped on a full table
    function automatic bit table_insert(word_t w, int n, logic [15:0] cnt);
        int pos;
        word_t z;
        pos = 0;
        if (used >= TABLE_ENTRIES)
            return 1;
        while (pos < used && compare_entry(pos, w, n) < 0)
            pos++;
        for (int i = used; i > pos; i--)
        begin
            tbl_chars[i] = tbl_chars[i-1];
            tbl_len[i]   = tbl_len[i-1];
            tbl_cnt[i]   = tbl_cnt[i-1];
        end
        for (int i = 0; i < MAX_WORD_LEN; i++)
            z[i] = (i < n) ? w[i] : 8'h00;
        tbl_chars[pos] = z;
        tbl_len[pos]   = n;
        tbl_cnt[pos]   = cnt;
        used++;
        return 0;
    endfunction

    function automatic void push_word(word_t w, int n, bit full);
        if (n == 0)
            emitted_q.push_back('{8'h00, 1'b1, full});
        for (int i = 0; i < n; i++)
            emitted_q.push_back('{w[i], (i + 1 == n), full});
    endfunction

    function automatic void predict_char(logic op, logic [7:0] ch, logic last);
        word_t w;
        int n, best, hit;
        logic [15:0] best_cnt;
        bit full, found;
        if (tok_len < MAX_WORD_LEN)
        begin
            tok[tok_len] = ch;
            tok_len++;
        end
        if (!last)
            return;
        n = tok_len;
        w = tok;
        tok_len = 0;
        if (op == OP_LOAD)
        begin
            if (table_insert(w, n, 16'd0))
                emitted_q.push_back('{8'h00, 1'b1, 1'b1});
            return;
        end
        if (n > 0 && w[n-1] == CHAR_STAR)
        begin
            n--;
            hit = -1;
            for (int i = 0; i < used; i++)
                if (hit < 0 && compare_entry(i, w, n) == 0)
                    hit = i;
            full = 0;
            if (hit >= 0)
            begin
                if (tbl_cnt[hit] != COUNT_MAX)
                    tbl_cnt[hit]++;
            end
            else
                full = table_insert(w, n, 16'd1);
            push_word(w, n, full);
            return;
        end
        if ((n == 1 && w[0] < CHAR_A) || w[0] > CHAR_Z)
        begin
            push_word(w, n, 0);
            return;
        end
        found = 0;
        best = 0;
        best_cnt = 0;
        for (int e = used - 1; e >= 0; e--)
            if (has_prefix(e, w, n) && best_cnt <= tbl_cnt[e])
            begin
                best_cnt = tbl_cnt[e];
                best = e;
                found = 1;
            end
        if (found)
        begin
            push_word(tbl_chars[best], tbl_len[best], 0);
            if (tbl_cnt[best] != COUNT_MAX)
                tbl_cnt[best]++;
            return;
        end
        full = table_insert(w, n, 16'd1);
        push_word(w, n, full);
    endfunction

    task automatic report_mismatch(string what);
        $display("%0t ns: mismatch: %s", $time, what);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        out_word_t exp_w;
        if (!rst_n)
        begin
            used = 0;
            tok_len = 0;
            fail_count = 0;
            emitted_q.delete();
            pending = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (emitted_q.size() == 0)
                    report_mismatch($sformatf("unexpected word char %h", out_char));
                else
                begin
                    exp_w = emitted_q.pop_front();
                    if (out_char !== exp_w.ch)
                        report_mismatch($sformatf("out_char %h, want %h",
                            out_char, exp_w.ch));
                    if (out_last !== exp_w.last)
                        report_mismatch($sformatf("out_last %b, want %b",
                            out_last, exp_w.last));
                    if (table_full !== exp_w.full)
                        report_mismatch($sformatf("table_full %b, want %b",
                            table_full, exp_w.full));
                end
            end
            if (in_valid && !in_stall)
                predict_char(opcode, in_char, in_last);
            pending = emitted_q.size();
        end
    end
endmodule

>>> sim/priority_prefix_autocomplete_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// priority_prefix_autocomplete_tb
// Drives dictionary loads and text tokens into the autocomplete block under
// random idling and back-pressure; the checker predicts and compares output.
// ----------------------------------------------------------------------------
module priority_prefix_autocomplete_tb;
    import ppa_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic       opcode;
    logic [7:0] in_char;
    logic       in_last;
    logic       out_valid;
    logic       out_stall;
    logic [7:0] out_char;
    logic       out_last;
    logic       table_full;
    int         fail_count;
    int         pending;

    int  send_idle_pct;
    int  recv_idle_pct;
    bit  hold_recv;
    int  idle_cycles;

    priority_prefix_autocomplete dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .opcode(opcode), .in_char(in_char), .in_last(in_last),
        .out_valid(out_valid), .out_stall(out_stall),
        .out_char(out_char), .out_last(out_last), .table_full(table_full)
    );

    ppa_checker chk (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .opcode(opcode), .in_char(in_char), .in_last(in_last),
        .out_valid(out_valid), .out_stall(out_stall),
        .out_char(out_char), .out_last(out_last), .table_full(table_full),
        .fail_count(fail_count), .pending(pending)
    );

    initial
    begin
        clk = 0;
        forever #6 clk = ~clk;
    end

    // receiver: random stall, or a long hold-off when asked
    initial
    begin
        out_stall = 1'b1;
        forever
        begin
            @(posedge clk);
            if (hold_recv)
            begin
                out_stall <= 1'b1;
                repeat (400) @(posedge clk);
                hold_recv = 0;
            end
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // watchdog on cycles without any accepted character
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic send_char(logic op, logic [7:0] ch, logic last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        opcode   <= op;
        in_char  <= ch;
        in_last  <= last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic send_string(logic op, string s);
        for (int i = 0; i < s.len(); i++)
            send_char(op, s[i], i + 1 == s.len());
    endtask

    function automatic string rand_word(int maxlen);
        string s;
        int n;
        s = "";
        n = $urandom_range(maxlen, 1);
        for (int i = 0; i < n; i++)
            s = {s, string'(byte'($urandom_range(CHAR_A + 4, CHAR_A)))};
        return s;
    endfunction

    task automatic send_random_token();
        int k;
        string s;
        k = $urandom_range(99);
        if (k < 15)
            send_string(OP_LOAD, rand_word(4));
        else if (k < 30)
            send_string(OP_TEXT, {rand_word(4), "*"});
        else if (k < 80)
            send_string(OP_TEXT, rand_word(3));
        else
        begin
            // noise: arbitrary bytes, random opcode
            s = "";
            for (int i = $urandom_range(3, 1); i > 0; i--)
                s = {s, string'(byte'($urandom_range(255)))};
            if (s[0] == 0)
                s[0] = 8'hFF;
            send_string(1'($urandom_range(1)), s);
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (400) @(posedge clk);
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        opcode = OP_LOAD;
        in_char = 8'h00;
        in_last = 1'b0;
        hold_recv = 0;
        idle_cycles = 0;
        send_idle_pct = 9;
        recv_idle_pct = 55;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part
        send_string(OP_LOAD, "apple");
        send_string(OP_LOAD, "apply");
        send_string(OP_LOAD, "apple");
        send_string(OP_TEXT, "app");
        send_string(OP_TEXT, "apply*");
        send_string(OP_TEXT, "zebra*");
        send_string(OP_TEXT, "*");
        send_string(OP_TEXT, "A");
        send_string(OP_TEXT, "{x");
        send_string(OP_TEXT, "\xff\x00\x80");
        send_string(OP_TEXT, "Bq");
        send_string(OP_TEXT, "abcdefghijklmnopqrstuv");
        send_char(OP_LOAD, 8'h55, 1'b0);
        send_char(OP_TEXT, 8'hAA, 1'b1);
        send_string(OP_TEXT, "ap");
        drain();

        for (int item = 0; item < 30; item++)
        begin
            if (item == 10)
            begin
                drain();
                send_idle_pct = 55;
                recv_idle_pct = 9;
            end
            if (item == 20)
            begin
                drain();
                send_idle_pct = 0;
                recv_idle_pct = 0;
                hold_recv = 1;
            end
            send_random_token();
        end
        // fill the table with equal one-letter words to reach the drop
        for (int i = 0; i < 64; i++)
            send_string(OP_LOAD, "q");
        send_string(OP_TEXT, "new*");
        send_string(OP_TEXT, "zz");
        // repeated bumps of one entry
        for (int i = 0; i < 8; i++)
            send_string(OP_TEXT, "q*");
        drain();

        if (fail_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule

>>> filelist.f
rtl/ppa_pkg.sv
rtl/ppa_ram.sv
rtl/ppa_ctrl.sv
rtl/ppa_dp.sv
rtl/priority_prefix_autocomplete.sv
sim/ppa_checker.sv
sim/priority_prefix_autocomplete_tb.sv
